// ===== hdl/assert_macros.svh =====
// Assertion helpers for the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled during reset
`define DGPR_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled during reset
`define DGPR_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/dgpr_pkg.sv =====
package dgpr_pkg;

  localparam int unsigned SCREEN_W_DEF = 320;
  localparam int unsigned SCREEN_H_DEF = 240;

  localparam int unsigned GLYPH_ROWS   = 7;
  localparam int unsigned GLYPH_COLS   = 5;
  localparam int unsigned NUM_DIGITS   = 10;
  localparam int unsigned ROM_DEPTH    = NUM_DIGITS * GLYPH_ROWS;
  localparam int unsigned ROM_AW       = $clog2(ROM_DEPTH);
  localparam int unsigned ROW_W        = $clog2(GLYPH_ROWS);
  localparam int unsigned COL_W        = $clog2(GLYPH_COLS);

  localparam logic [7:0] CHAR_ZERO = 8'd48;
  localparam logic [7:0] CHAR_NINE = 8'd57;

  localparam logic signed [11:0] CHAR_ADVANCE = 12'sd6;
  localparam logic signed [11:0] CURSOR_MAX   = 12'sd2047;
  localparam logic signed [11:0] CURSOR_SAT   = CURSOR_MAX - CHAR_ADVANCE;

  typedef logic [GLYPH_COLS-1:0] glyph_row_t;

  // rows of each digit, top row first; bit 4 is the left column
  localparam glyph_row_t GLYPH_ROM [ROM_DEPTH] = '{
    5'h0E, 5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h0E,
    5'h04, 5'h0C, 5'h04, 5'h04, 5'h04, 5'h04, 5'h0E,
    5'h0E, 5'h11, 5'h01, 5'h06, 5'h08, 5'h10, 5'h1F,
    5'h1F, 5'h02, 5'h04, 5'h02, 5'h01, 5'h11, 5'h0E,
    5'h02, 5'h06, 5'h0A, 5'h12, 5'h1F, 5'h02, 5'h02,
    5'h1F, 5'h10, 5'h1E, 5'h01, 5'h01, 5'h11, 5'h0E,
    5'h0E, 5'h10, 5'h1E, 5'h11, 5'h11, 5'h11, 5'h0E,
    5'h1F, 5'h01, 5'h02, 5'h04, 5'h08, 5'h08, 5'h08,
    5'h0E, 5'h11, 5'h11, 5'h0E, 5'h11, 5'h11, 5'h0E,
    5'h0E, 5'h11, 5'h11, 5'h0F, 5'h01, 5'h11, 5'h0E
  };

  typedef struct packed {
    logic              start_of_text;
    logic signed [11:0] start_x;
    logic signed [11:0] start_y;
    logic [7:0]        char_code;
    logic [15:0]       color;
  } dgpr_in_t;

  typedef struct packed {
    logic [31:0] fb_addr;
    logic [8:0]  pixel_x;
    logic [9:0]  pixel_y;
    logic [15:0] pixel_color;
    logic        last;
  } dgpr_out_t;

  typedef struct packed {
    logic signed [11:0] x;
    logic signed [11:0] y;
  } cursor_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOAD,
    ST_SCAN,
    ST_FLUSH
  } state_t;

endpackage

// ===== hdl/dgpr_font_rom.sv =====
module dgpr_font_rom (
  input  logic                        clk,
  input  logic                        rd_en,
  input  logic [dgpr_pkg::ROM_AW-1:0] rd_addr,
  output dgpr_pkg::glyph_row_t        rd_data
);

  dgpr_pkg::glyph_row_t rd_data_r;

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= dgpr_pkg::GLYPH_ROM[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ===== hdl/dgpr_cursor_mem.sv =====
module dgpr_cursor_mem (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              rd_en,
  output dgpr_pkg::cursor_t rd_data,
  input  logic              wr_en,
  input  dgpr_pkg::cursor_t wr_data
);

  dgpr_pkg::cursor_t mem [1];
  dgpr_pkg::cursor_t rd_data_r;
  logic              vld_r;
  logic              vld_nxt;

  assign vld_nxt = vld_r | wr_en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[0] <= wr_data;
    end
  end

  // entry reads as zero until first written after reset
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= vld_r ? mem[0] : '0;
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ===== hdl/digit_glyph_pixel_renderer.sv =====
// Digit character generator. Each accepted word is one character; a digit '0'..'9' is
// drawn from a 5x7 font and gives one output word per visible set pixel (row by row,
// left column first), each with frame buffer address base + y*1024 + x*2; last marks
// the final pixel of the character. Anything else draws nothing but still moves the
// cursor right by 6 (saturating at 2047). The cursor lives in a one-entry synchronous
// store and the font in a synchronous ROM read one row at a time. A digit passes through
// accept, cursor read, a scan of the 35 glyph cells (one per cycle unless a ready pixel
// waits on a stalled output) and a final flush; other characters take only accept and
// cursor read. cfg_wr_data sets the frame buffer base and may only be written while
// the block is idle.
`include "assert_macros.svh"

module digit_glyph_pixel_renderer #(
  parameter int unsigned SCREEN_W = dgpr_pkg::SCREEN_W_DEF,
  parameter int unsigned SCREEN_H = dgpr_pkg::SCREEN_H_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_wr_en,
  input  logic [31:0]        cfg_wr_data,
  input  logic               in_valid,
  output logic               in_stall,
  input  dgpr_pkg::dgpr_in_t in_word,
  output logic               out_valid,
  input  logic               out_stall,
  output dgpr_pkg::dgpr_out_t out_word
);

  localparam logic [dgpr_pkg::COL_W-1:0] COL_LAST = dgpr_pkg::COL_W'(dgpr_pkg::GLYPH_COLS - 1);
  localparam logic [dgpr_pkg::ROW_W-1:0] ROW_LAST = dgpr_pkg::ROW_W'(dgpr_pkg::GLYPH_ROWS - 1);

  dgpr_pkg::state_t   state_r, state_nxt;
  dgpr_pkg::dgpr_in_t item_r;
  dgpr_pkg::cursor_t  cur_r;
  logic [31:0]        base_r;

  logic [dgpr_pkg::ROW_W-1:0] row_r, row_nxt;
  logic [dgpr_pkg::COL_W-1:0] col_r, col_nxt;

  logic       pnd_valid_r, pnd_valid_nxt;
  logic [8:0] pnd_x_r;
  logic [9:0] pnd_y_r;

  logic                out_valid_r, out_valid_nxt;
  dgpr_pkg::dgpr_out_t out_word_r;

  dgpr_pkg::cursor_t    cur_rd_data, cur_now, cur_wr_data;
  dgpr_pkg::glyph_row_t rom_q;
  logic [dgpr_pkg::ROM_AW-1:0] rom_addr, glyph_base;
  logic [3:0]  digit;
  logic        is_digit;
  logic        cur_rd_en, cur_wr_en, rom_rd_en;
  logic        scan_adv, pnd_load, pnd_move, move_last;
  logic        out_free, bit_set, visible;
  logic [12:0] px, py;
  logic        in_acc, out_on_screen, scan_in_glyph;

  // ---------------- stores ----------------
  dgpr_cursor_mem u_cursor (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_en   (cur_rd_en),
    .rd_data (cur_rd_data),
    .wr_en   (cur_wr_en),
    .wr_data (cur_wr_data)
  );

  dgpr_font_rom u_font (
    .clk     (clk),
    .rd_en   (rom_rd_en),
    .rd_addr (rom_addr),
    .rd_data (rom_q)
  );

  // ---------------- datapath ----------------
  assign is_digit   = (item_r.char_code >= dgpr_pkg::CHAR_ZERO) &&
                      (item_r.char_code <= dgpr_pkg::CHAR_NINE);
  assign digit      = 4'(item_r.char_code - dgpr_pkg::CHAR_ZERO);
  assign glyph_base = dgpr_pkg::ROM_AW'(digit) * dgpr_pkg::ROM_AW'(dgpr_pkg::GLYPH_ROWS);

  assign cur_now = item_r.start_of_text ?
                   dgpr_pkg::cursor_t'{x: item_r.start_x, y: item_r.start_y} : cur_rd_data;

  always_comb begin
    cur_wr_data.y = cur_now.y;
    cur_wr_data.x = (cur_now.x > dgpr_pkg::CURSOR_SAT) ? dgpr_pkg::CURSOR_MAX
                                                       : cur_now.x + dgpr_pkg::CHAR_ADVANCE;
  end

  assign px = {cur_r.x[11], cur_r.x} + 13'(col_r);
  assign py = {cur_r.y[11], cur_r.y} + 13'(row_r);

  assign bit_set = rom_q[COL_LAST - col_r];
  assign visible = bit_set &&
                   !px[12] && (px[11:0] < 12'(SCREEN_W)) &&
                   !py[12] && (py[11:0] < 12'(SCREEN_H));

  assign out_free = !out_valid_r || !out_stall;

  // ---------------- sequencer ----------------
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      dgpr_pkg::ST_IDLE: begin
        if (in_valid) state_nxt = dgpr_pkg::ST_LOAD;
      end
      dgpr_pkg::ST_LOAD: begin
        state_nxt = is_digit ? dgpr_pkg::ST_SCAN : dgpr_pkg::ST_IDLE;
      end
      dgpr_pkg::ST_SCAN: begin
        if (scan_adv && row_r == ROW_LAST && col_r == COL_LAST) state_nxt = dgpr_pkg::ST_FLUSH;
      end
      dgpr_pkg::ST_FLUSH: begin
        if (!pnd_valid_r || out_free) state_nxt = dgpr_pkg::ST_IDLE;
      end
      default: state_nxt = dgpr_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_stall  = 1'b1;
    cur_rd_en = 1'b0;
    cur_wr_en = 1'b0;
    rom_rd_en = 1'b0;
    rom_addr  = glyph_base;
    scan_adv  = 1'b0;
    pnd_load  = 1'b0;
    pnd_move  = 1'b0;
    move_last = 1'b0;
    unique case (state_r)
      dgpr_pkg::ST_IDLE: begin
        in_stall  = 1'b0;
        cur_rd_en = in_valid;
      end
      dgpr_pkg::ST_LOAD: begin
        // cursor written back once per item; the next read is only issued later, from idle
        cur_wr_en = 1'b1;
        rom_rd_en = is_digit;
      end
      dgpr_pkg::ST_SCAN: begin
        // a held pixel leaves only when a newer one replaces it, so last is known
        scan_adv  = !visible || !pnd_valid_r || out_free;
        pnd_load  = visible && scan_adv;
        pnd_move  = visible && pnd_valid_r && out_free;
        rom_rd_en = scan_adv && (col_r == COL_LAST) && (row_r != ROW_LAST);
        rom_addr  = glyph_base + dgpr_pkg::ROM_AW'(row_r) + dgpr_pkg::ROM_AW'(1);
      end
      dgpr_pkg::ST_FLUSH: begin
        pnd_move  = pnd_valid_r && out_free;
        move_last = 1'b1;
      end
      default: begin
        in_stall = 1'b1;
      end
    endcase
  end

  always_comb begin
    row_nxt = row_r;
    col_nxt = col_r;
    if (state_r == dgpr_pkg::ST_LOAD) begin
      row_nxt = '0;
      col_nxt = '0;
    end else if (scan_adv) begin
      if (col_r == COL_LAST) begin
        col_nxt = '0;
        row_nxt = row_r + 1'b1;
      end else begin
        col_nxt = col_r + 1'b1;
      end
    end
  end

  always_comb begin
    pnd_valid_nxt = pnd_valid_r;
    if (pnd_load) pnd_valid_nxt = 1'b1;
    else if (pnd_move) pnd_valid_nxt = 1'b0;
  end

  always_comb begin
    out_valid_nxt = out_valid_r && out_stall;
    if (pnd_move) out_valid_nxt = 1'b1;
  end

  // ---------------- registers ----------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= dgpr_pkg::ST_IDLE;
      row_r       <= '0;
      col_r       <= '0;
      pnd_valid_r <= 1'b0;
      out_valid_r <= 1'b0;
      base_r      <= '0;
    end else begin
      state_r     <= state_nxt;
      row_r       <= row_nxt;
      col_r       <= col_nxt;
      pnd_valid_r <= pnd_valid_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_wr_en) base_r <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) item_r <= in_word;
    if (state_r == dgpr_pkg::ST_LOAD) cur_r <= cur_now;
    if (pnd_load) begin
      pnd_x_r <= px[8:0];
      pnd_y_r <= py[9:0];
    end
    if (pnd_move) begin
      out_word_r.fb_addr     <= base_r + {12'd0, pnd_y_r, pnd_x_r, 1'b0};
      out_word_r.pixel_x     <= pnd_x_r;
      out_word_r.pixel_y     <= pnd_y_r;
      out_word_r.pixel_color <= item_r.color;
      out_word_r.last        <= move_last;
    end
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

  // ---------------- checks ----------------
  assign in_acc        = in_valid && !in_stall;
  assign out_on_screen = (32'(out_word_r.pixel_x) < SCREEN_W) &&
                         (32'(out_word_r.pixel_y) < SCREEN_H);
  assign scan_in_glyph = (row_r <= ROW_LAST) && (col_r <= COL_LAST);

  `DGPR_ASSERT_NOW(a_idle_no_pending, !in_stall, !pnd_valid_r, "pixel held while idle")
  `DGPR_ASSERT_NOW(a_out_on_screen, out_valid_r, out_on_screen, "clipped pixel emitted")
  `DGPR_ASSERT_NOW(a_scan_range, state_r == dgpr_pkg::ST_SCAN, scan_in_glyph, "scan out of glyph")
  `DGPR_ASSERT_NEXT(a_accept_loads, in_acc, state_r == dgpr_pkg::ST_LOAD, "word not loaded")

endmodule

// ===== tb/sv/digit_glyph_pixel_renderer_tb.sv =====
module digit_glyph_pixel_renderer_tb;

  localparam int SCR_W = 320;
  localparam int SCR_H = 240;
  localparam int CYCLE_LIMIT = 400000;
  // one digit still runs its full glyph scan even when every pixel is clipped
  localparam int SETTLE_CYCLES = 48;

  // 5x7 font, top row first, bit 4 is the left column
  localparam logic [4:0] DIGIT_FONT [10][7] = '{
    '{5'h0E, 5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h0E},
    '{5'h04, 5'h0C, 5'h04, 5'h04, 5'h04, 5'h04, 5'h0E},
    '{5'h0E, 5'h11, 5'h01, 5'h06, 5'h08, 5'h10, 5'h1F},
    '{5'h1F, 5'h02, 5'h04, 5'h02, 5'h01, 5'h11, 5'h0E},
    '{5'h02, 5'h06, 5'h0A, 5'h12, 5'h1F, 5'h02, 5'h02},
    '{5'h1F, 5'h10, 5'h1E, 5'h01, 5'h01, 5'h11, 5'h0E},
    '{5'h0E, 5'h10, 5'h1E, 5'h11, 5'h11, 5'h11, 5'h0E},
    '{5'h1F, 5'h01, 5'h02, 5'h04, 5'h08, 5'h08, 5'h08},
    '{5'h0E, 5'h11, 5'h11, 5'h0E, 5'h11, 5'h11, 5'h0E},
    '{5'h0E, 5'h11, 5'h11, 5'h0F, 5'h01, 5'h11, 5'h0E}
  };

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                cfg_wr_en = 1'b0;
  logic [31:0]         cfg_wr_data = '0;
  logic                in_valid = 1'b0;
  logic                in_stall;
  dgpr_pkg::dgpr_in_t  in_word = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  dgpr_pkg::dgpr_out_t out_word;

  // predictor state
  logic [31:0]         fb_base = '0;
  int                  cursor_col = 0;
  int                  cursor_row = 0;
  dgpr_pkg::dgpr_out_t pending_pixels[$];

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int mismatches = 0;
  int chars_sent = 0;
  int pixels_checked = 0;
  int cycle_cnt = 0;

  digit_glyph_pixel_renderer #(
    .SCREEN_W(SCR_W),
    .SCREEN_H(SCR_H)
  ) DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_word    (in_word),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_word   (out_word)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d pixels still pending",
               cycle_cnt, pending_pixels.size());
      $display("*** FAILED ***");
      $finish;
    end
  end

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    mismatches++;
    $display("MISMATCH pixel %0d %s: got %0h expected %0h", pixels_checked, what, got,
             want);
  endtask

  // expected pixel words for one accepted character
  function automatic void draw_digit_pixels(input dgpr_pkg::dgpr_in_t w);
    int px;
    int py;
    int n;
    int idx;
    dgpr_pkg::dgpr_out_t pix;
    n = 0;
    if (w.start_of_text) begin
      cursor_col = $signed(w.start_x);
      cursor_row = $signed(w.start_y);
    end
    if (w.char_code >= dgpr_pkg::CHAR_ZERO && w.char_code <= dgpr_pkg::CHAR_NINE) begin
      idx = int'(w.char_code - dgpr_pkg::CHAR_ZERO);
      for (int r = 0; r < dgpr_pkg::GLYPH_ROWS; r++) begin
        for (int c = 0; c < dgpr_pkg::GLYPH_COLS; c++) begin
          px = cursor_col + c;
          py = cursor_row + r;
          if (!DIGIT_FONT[idx][r][4-c]) continue;
          if (px < 0 || px >= SCR_W || py < 0 || py >= SCR_H) continue;
          pix.fb_addr     = fb_base + 32'(py) * 32'd1024 + 32'(px) * 32'd2;
          pix.pixel_x     = 9'(px);
          pix.pixel_y     = 10'(py);
          pix.pixel_color = w.color;
          pix.last        = 1'b0;
          pending_pixels.push_back(pix);
          n++;
        end
      end
      if (n > 0) pending_pixels[$].last = 1'b1;
    end
    if (cursor_col > int'(dgpr_pkg::CURSOR_SAT)) cursor_col = int'(dgpr_pkg::CURSOR_MAX);
    else cursor_col = cursor_col + int'(dgpr_pkg::CHAR_ADVANCE);
  endfunction

  // pixel checker and receiver stall
  always @(posedge clk) begin
    dgpr_pkg::dgpr_out_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_pixels.size() == 0) begin
        report_mismatch("with nothing pending, addr", out_word.fb_addr, '0);
      end else begin
        want = pending_pixels.pop_front();
        if (out_word.fb_addr !== want.fb_addr)
          report_mismatch("fb_addr", out_word.fb_addr, want.fb_addr);
        if (out_word.pixel_x !== want.pixel_x)
          report_mismatch("pixel_x", 32'(out_word.pixel_x), 32'(want.pixel_x));
        if (out_word.pixel_y !== want.pixel_y)
          report_mismatch("pixel_y", 32'(out_word.pixel_y), 32'(want.pixel_y));
        if (out_word.pixel_color !== want.pixel_color)
          report_mismatch("pixel_color", 32'(out_word.pixel_color),
                          32'(want.pixel_color));
        if (out_word.last !== want.last)
          report_mismatch("last", 32'(out_word.last), 32'(want.last));
      end
      pixels_checked++;
    end
    out_stall <= ($urandom_range(99) < recv_stall_pct);
  end

  function automatic dgpr_pkg::dgpr_in_t mk_char(input bit sot, input int x, input int y,
                                                 input int code, input int colr);
    dgpr_pkg::dgpr_in_t w;
    w.start_of_text = sot;
    w.start_x       = 12'(x);
    w.start_y       = 12'(y);
    w.char_code     = 8'(code);
    w.color         = 16'(colr);
    return w;
  endfunction

  // called at a rising edge; returns at the edge where the word is taken
  task automatic send_char(input dgpr_pkg::dgpr_in_t w);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_word  <= w;
    do @(posedge clk); while (in_stall);
    draw_digit_pixels(w);
    chars_sent++;
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (pending_pixels.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_buffer_base(input logic [31:0] v);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    fb_base = v;
  endtask

  task automatic test_all_digits();
    write_buffer_base(32'h1000_0000);
    send_char(mk_char(1, 10, 20, dgpr_pkg::CHAR_ZERO, 16'h0000));
    for (int d = 1; d < 10; d++)
      send_char(mk_char(0, -2048, 2047, dgpr_pkg::CHAR_ZERO + d, 16'hFFFF - d));
    wait_drained();
  endtask

  task automatic test_screen_clipping();
    write_buffer_base(32'hFFFF_FFFF);
    send_char(mk_char(1, -3, 5, dgpr_pkg::CHAR_ZERO + 8, 16'hA5A5));
    send_char(mk_char(1, 317, 5, dgpr_pkg::CHAR_ZERO, 16'h5A5A));
    send_char(mk_char(1, 50, -4, dgpr_pkg::CHAR_ZERO + 2, 16'h0001));
    send_char(mk_char(1, 60, 236, dgpr_pkg::CHAR_ZERO + 3, 16'h8000));
    send_char(mk_char(1, 0, 0, dgpr_pkg::CHAR_ZERO + 8, 16'hFFFF));
    send_char(mk_char(1, 315, 233, dgpr_pkg::CHAR_ZERO + 8, 16'h1234));
    // nothing visible at the far corners
    send_char(mk_char(1, -2048, -2048, dgpr_pkg::CHAR_ZERO + 4, 16'h4321));
    send_char(mk_char(1, 2047, 2047, dgpr_pkg::CHAR_ZERO + 5, 16'h0F0F));
    wait_drained();
  endtask

  task automatic test_non_digit_and_saturation();
    write_buffer_base(32'h0000_0000);
    send_char(mk_char(1, 100, 100, 0, 16'h1111));
    send_char(mk_char(0, 0, 0, 255, 16'h2222));
    send_char(mk_char(0, 0, 0, dgpr_pkg::CHAR_ZERO - 1, 16'h3333));
    send_char(mk_char(0, 0, 0, dgpr_pkg::CHAR_NINE + 1, 16'h4444));
    // cursor should sit at 124 now
    send_char(mk_char(0, 0, 0, dgpr_pkg::CHAR_ZERO + 7, 16'h5555));
    // advance past 2041 saturates at 2047
    send_char(mk_char(1, 2040, 50, dgpr_pkg::CHAR_ZERO + 1, 16'h6666));
    send_char(mk_char(0, 0, 0, dgpr_pkg::CHAR_ZERO + 6, 16'h7777));
    send_char(mk_char(0, 0, 0, dgpr_pkg::CHAR_ZERO + 9, 16'h8888));
    wait_drained();
  endtask

  function automatic dgpr_pkg::dgpr_in_t random_char();
    dgpr_pkg::dgpr_in_t w;
    w.start_of_text = ($urandom_range(99) < 30);
    if ($urandom_range(99) < 70) begin
      w.start_x = 12'($urandom_range(SCR_W + 8) - 8);
      w.start_y = 12'($urandom_range(SCR_H + 8) - 8);
    end else begin
      w.start_x = 12'($urandom);
      w.start_y = 12'($urandom);
    end
    if ($urandom_range(99) < 80) w.char_code = dgpr_pkg::CHAR_ZERO + 8'($urandom_range(9));
    else w.char_code = 8'($urandom);
    w.color = 16'($urandom);
    return w;
  endfunction

  task automatic test_random_text(input int count, input logic [31:0] base);
    write_buffer_base(base);
    for (int i = 0; i < count; i++) begin
      send_char(random_char());
      // hold off once mid-phase until every pixel is out
      if (i == count / 2) wait_drained();
    end
    wait_drained();
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_idle_pct  = 16;
    recv_stall_pct = 66;
    test_all_digits();
    test_screen_clipping();
    test_non_digit_and_saturation();
    test_random_text(32, $urandom);

    send_idle_pct  = 66;
    recv_stall_pct = 16;
    test_random_text(32, 32'hFFFF_F000);

    send_idle_pct  = 0;
    recv_stall_pct = 0;
    test_random_text(32, 32'h0000_0000);

    in_valid <= 1'b0;
    while (pending_pixels.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("Drew %0d characters, checked %0d pixel words in %0d cycles, %0d mismatches.",
             chars_sent, pixels_checked, cycle_cnt, mismatches);
    $display("Covered all digits, clipping on every edge, non-digits, cursor saturation,");
    $display("several frame buffer bases and three sender/receiver idle mixes.");
    if (mismatches == 0 && pending_pixels.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
